[rtl/core/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_CONTROL  = 3'd1;
   localparam logic [2:0] ERR_ESCAPE   = 3'd2;
   localparam logic [2:0] ERR_HEX      = 3'd3;
   localparam logic [2:0] ERR_UNTERM   = 3'd4;

   // Most result words one input byte can cause
   localparam int MAX_RESULTS = 3;

   // Output queue; depth must be a power of two
   localparam int QDEPTH  = 8;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       run_last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]                         count;
      rsp_word_type [MAX_RESULTS-1:0]     words;
   } rsp_bundle_type;

endpackage

`default_nettype wire

[rtl/core/jsu_decode.sv]
// Escape decoder: phase and hex accumulator registers plus the per-byte decode logic.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    strict_mode,
   input  wire logic                    step,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    input_end,
   output jsu_pkg::rsp_bundle_type      bundle
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_HEX0,
      PH_HEX1,
      PH_HEX2,
      PH_HEX3,
      PH_WAIT
   } phase_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CTRL_MAX = 8'h1f;

   phase_type   phase_ff, phase_in;
   logic [11:0] accum_ff, accum_in;

   logic [4:0]  hex;      // {valid, value}
   logic [15:0] code;
   logic [1:0]  count;
   rsp_word_type [MAX_RESULTS-1:0] words;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic rsp_word_type mk(input logic [7:0] b, input logic [1:0] k,
                                       input logic [2:0] e);
      rsp_word_type w;
      w.out_byte   = b;
      w.kind       = k;
      w.error_code = e;
      w.run_last   = 1'b0;
      return w;
   endfunction

   assign hex  = hex_digit(in_byte);
   assign code = {accum_ff, hex[3:0]};

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      count    = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) words[i] = mk(8'd0, KIND_BYTE, ERR_NONE);

      if (phase_ff == PH_WAIT) begin
         if (!input_end && in_byte == CH_QUOTE) begin
            phase_in = PH_NORMAL;
            accum_in = 12'd0;
         end
      end else if (input_end) begin
         phase_in = PH_WAIT;
         accum_in = 12'd0;
         count    = 2'd1;
         words[0] = mk(8'd0, KIND_ERROR, ERR_UNTERM);
      end else begin
         case (phase_ff)
            PH_NORMAL: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in = PH_WAIT;
                  accum_in = 12'd0;
                  count    = 2'd1;
                  words[0] = mk(8'd0, KIND_CLOSE, ERR_NONE);
               end else if (in_byte <= CTRL_MAX && strict_mode) begin
                  phase_in = PH_WAIT;
                  accum_in = 12'd0;
                  count    = 2'd1;
                  words[0] = mk(8'd0, KIND_ERROR, ERR_CONTROL);
               end else if (in_byte == CH_BSL) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  count    = 2'd1;
                  words[0] = mk(in_byte, KIND_BYTE, ERR_NONE);
               end
            end
            PH_ESCAPE: begin
               phase_in = PH_NORMAL;
               count    = 2'd1;
               case (in_byte)
                  CH_QUOTE, CH_BSL, CH_SLASH: words[0] = mk(in_byte, KIND_BYTE, ERR_NONE);
                  CH_B: words[0] = mk(8'h08, KIND_BYTE, ERR_NONE);
                  CH_F: words[0] = mk(8'h0c, KIND_BYTE, ERR_NONE);
                  CH_N: words[0] = mk(8'h0a, KIND_BYTE, ERR_NONE);
                  CH_R: words[0] = mk(8'h0d, KIND_BYTE, ERR_NONE);
                  CH_T: words[0] = mk(8'h09, KIND_BYTE, ERR_NONE);
                  CH_U: begin
                     phase_in = PH_HEX0;
                     accum_in = 12'd0;
                     count    = 2'd0;
                  end
                  default: begin
                     if (strict_mode) begin
                        phase_in = PH_WAIT;
                        accum_in = 12'd0;
                        words[0] = mk(8'd0, KIND_ERROR, ERR_ESCAPE);
                     end else begin
                        count    = 2'd2;
                        words[0] = mk(CH_BSL, KIND_BYTE, ERR_NONE);
                        words[1] = mk(in_byte, KIND_BYTE, ERR_NONE);
                     end
                  end
               endcase
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
               if (!hex[4]) begin
                  phase_in = PH_WAIT;
                  accum_in = 12'd0;
                  count    = 2'd1;
                  words[0] = mk(8'd0, KIND_ERROR, ERR_HEX);
               end else if (phase_ff == PH_HEX3) begin
                  phase_in = PH_NORMAL;
                  accum_in = 12'd0;
                  if (code <= 16'h007f) begin
                     count    = 2'd1;
                     words[0] = mk(code[7:0], KIND_BYTE, ERR_NONE);
                  end else if (code <= 16'h07ff) begin
                     count    = 2'd2;
                     words[0] = mk(8'hc0 | {3'd0, code[10:6]}, KIND_BYTE, ERR_NONE);
                     words[1] = mk(8'h80 | {2'd0, code[5:0]}, KIND_BYTE, ERR_NONE);
                  end else begin
                     count    = 2'd3;
                     words[0] = mk(8'he0 | {4'd0, code[15:12]}, KIND_BYTE, ERR_NONE);
                     words[1] = mk(8'h80 | {2'd0, code[11:6]}, KIND_BYTE, ERR_NONE);
                     words[2] = mk(8'h80 | {2'd0, code[5:0]}, KIND_BYTE, ERR_NONE);
                  end
               end else begin
                  accum_in = {accum_ff[7:0], hex[3:0]};
                  case (phase_ff)
                     PH_HEX0: phase_in = PH_HEX1;
                     PH_HEX1: phase_in = PH_HEX2;
                     default: phase_in = PH_HEX3;
                  endcase
               end
            end
            default: begin
               phase_in = PH_WAIT;
               accum_in = 12'd0;
            end
         endcase
      end

      // mark the last word of this byte's run
      for (int i = 0; i < MAX_RESULTS; i++) begin
         words[i].run_last = (2'(i + 1) == count);
      end

      bundle.count = count;
      bundle.words = words;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         accum_ff <= 12'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/jsu_queue.sv]
// Result queue: takes up to three words per cycle, hands out one word per cycle.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire jsu_pkg::rsp_bundle_type       push_bundle,
   input  wire logic                          pop,
   output jsu_pkg::rsp_word_type              head,
   output logic [jsu_pkg::QCNT_W-1:0]         count
);
   import jsu_pkg::*;

   rsp_word_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic [1:0]               n_push;
   logic                     do_pop;

   assign n_push = push ? push_bundle.count : 2'd0;
   assign do_pop = pop && (count_ff != '0);

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
   assign count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < n_push) begin
            mem_ff[QPTR_W'(wr_ptr_ff + QPTR_W'(i))] <= push_bundle.words[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

`default_nettype wire

[rtl/core/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper with UTF-8 output.
// Usage:
//   req channel: one raw byte of a string body per word, starting after the
//   opening quote; req_input_end marks the end of the buffer.
//   rsp channel: one result word per cycle: a decoded byte, a close marker
//   or an error; rsp_run_last flags the last word caused by one req word.
//   csr channel: writes strict_mode; always ready. Write only while idle.
// Path: an accepted req word is held in the input stage register, decoded
//   from it and pushed into the queue when the stage steps.
// Throughput: one req word per cycle. A \u escape yields up to three words
//   from its last hex digit, drained one per cycle by the eight-word queue.
//   The input stage steps only while the queue has room for three words.
// Reset: strict mode on, decoder outside any escape, queue empty.
// Stall: when rsp_ready is low the queue fills, the input stage holds and
//   req_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_input_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_strict_mode
);
   import jsu_pkg::*;

   localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QDEPTH - MAX_RESULTS);

   logic              strict_ff, strict_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   logic              s1_end_ff;
   logic              req_accept;
   logic              step;
   rsp_bundle_type    bundle;
   rsp_word_type      head;
   logic [QCNT_W-1:0] q_count;

   // Config register: always ready, take the new mode on a write.
   assign csr_ready = 1'b1;
   assign strict_in = (csr_valid && csr_ready) ? csr_strict_mode : strict_ff;

   // Input stage advances when the queue can absorb a full run of words.
   assign step        = s1_valid_ff && (q_count <= ROOM_LIMIT);
   assign req_ready   = !s1_valid_ff || step;
   assign req_accept  = req_valid && req_ready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff   <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         strict_ff   <= strict_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload of the input stage: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_in_byte;
         s1_end_ff  <= req_input_end;
      end
   end

   jsu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .strict_mode (strict_ff),
      .step        (step),
      .in_byte     (s1_byte_ff),
      .input_end   (s1_end_ff),
      .bundle      (bundle)
   );

   jsu_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (step),
      .push_bundle (bundle),
      .pop         (rsp_ready),
      .head        (head),
      .count       (q_count)
   );

   // Drive the result channel from the queue head.
   assign rsp_valid      = (q_count != '0);
   assign rsp_out_byte   = head.out_byte;
   assign rsp_kind       = head.kind;
   assign rsp_error_code = head.error_code;
   assign rsp_run_last   = head.run_last;

   // Queue never overfills.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   // A stalled input stage keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step) |=> (s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_end_ff)))
      else $error("input stage lost a word");

   // Close and error words always end their run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> rsp_run_last)
      else $error("close or error word not last in run");

   // Non-error words carry no error code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_ERROR) |-> (rsp_error_code == ERR_NONE))
      else $error("error code on a non-error word");

endmodule

`default_nettype wire
